// ===== rtl/mmvc_pkg.sv =====
// shared types, constants and codes for the marginal missing-value counter
// depends on nothing; the controller, datapath and top refer to it by scoped names
`default_nettype none

package mmvc_pkg;

	// sizing constants
	localparam int unsigned MAX_DIMS    = 4;
	localparam int unsigned TABLE_CELLS = 4096;
	localparam int unsigned COUNT_BITS  = 32;

	// fixed field widths
	localparam int unsigned DIM_REGS  = 4;
	localparam int unsigned DIG_W     = 16;
	localparam int unsigned RIDX_W    = 12;
	localparam int unsigned CNT_OUT_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	// derived constants
	localparam int unsigned DIM_LIM = (MAX_DIMS < DIM_REGS) ? MAX_DIMS : DIM_REGS;
	localparam int unsigned ADDR_W  = (TABLE_CELLS > 1) ? $clog2(TABLE_CELLS) : 1;
	localparam int unsigned PROD_W  = $clog2(TABLE_CELLS + 1);

	// item modes
	localparam logic [1:0] MODE_ELEMENT = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_DIM_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM0_SIZE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM1_SIZE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM2_SIZE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM3_SIZE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KEPT_DIM_COUNT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KEPT_DIM_SELECT = 3'd6;

	typedef struct packed {
		logic [1:0]        mode;
		logic              is_missing;
		logic [RIDX_W-1:0] read_index;
	} item_t;

	typedef struct packed {
		logic [CNT_OUT_W-1:0] count_value;
		logic                 index_valid;
	} result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_FETCH,
		S_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic advance;
		logic clr_digits;
		logic rd_en;
		logic wr_cnt;
		logic clr_wr;
		logic reply;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic calc_done;
		logic clr_last;
		logic read_item;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/marginal_missing_value_counter_top.sv =====
// marginal missing-value counter: a present element leaves busy low; a missing element or
// a cell read holds busy through the index build, which steps one kept dimension per cycle
// up to k, the clamped kept dimension count, and through the table read-modify-write
// a read's result strobes in the first cycle with busy low; the receiver cannot stall
// after reset and after each restart a clearing pass writes all 4096 cells with busy high
// depends on mmvc_pkg, mmvc_ctrl, mmvc_dpath, mmvc_ram
`default_nettype none

module marginal_missing_value_counter_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire mmvc_pkg::item_t                item,
	output logic                                result_valid,
	output mmvc_pkg::result_t                   result,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [mmvc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mmvc_pkg::CFG_DAT_W-1:0] cfg_data
);

	mmvc_pkg::cmd_t    cmd;
	mmvc_pkg::status_t status;

	assign cfg_ready = 1'b1;

	mmvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (item.mode),
		.is_missing(item.is_missing),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	mmvc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.result_valid(result_valid),
		.result      (result)
	);

	// a result transfer lasts a single cycle
	a_result_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held for more than one cycle");

	// the result comes once the item has finished
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while still busy");

	// restart starts a clearing pass
	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == mmvc_pkg::MODE_RESTART) |=> busy)
		else $error("restart did not start clearing");

	// an out of range read reports a zero count
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.index_valid) |-> (result.count_value == '0))
		else $error("invalid read returned a non-zero count");

	// clearing never overlaps a count update
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !(cmd.wr_cnt || cmd.rd_en || cmd.reply))
		else $error("clearing overlaps table access");

endmodule

`default_nettype wire

// ===== rtl/mmvc_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module mmvc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mmvc_ctrl.sv =====
// controller state machine: sequences clearing, index build, table access
// depends on mmvc_pkg
`default_nettype none

module mmvc_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [1:0]       mode,
	input  wire logic             is_missing,
	input  wire mmvc_pkg::status_t status,
	output mmvc_pkg::cmd_t        cmd,
	output logic                  busy
);

	mmvc_pkg::state_t state_q, state_d;
	logic             accept;

	assign accept = start && (state_q == mmvc_pkg::S_IDLE);
	assign busy   = (state_q != mmvc_pkg::S_IDLE);

	// state register, clearing pass runs straight after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmvc_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mmvc_pkg::S_CLEAR: begin
				if (status.clr_last) state_d = mmvc_pkg::S_IDLE;
			end
			mmvc_pkg::S_IDLE: begin
				if (accept) begin
					case (mode)
						mmvc_pkg::MODE_ELEMENT: begin
							if (is_missing) state_d = mmvc_pkg::S_CALC;
						end
						mmvc_pkg::MODE_READ:    state_d = mmvc_pkg::S_CALC;
						mmvc_pkg::MODE_RESTART: state_d = mmvc_pkg::S_CLEAR;
						default:                state_d = mmvc_pkg::S_IDLE;
					endcase
				end
			end
			mmvc_pkg::S_CALC: begin
				if (status.calc_done) state_d = mmvc_pkg::S_FETCH;
			end
			mmvc_pkg::S_FETCH:  state_d = mmvc_pkg::S_UPDATE;
			mmvc_pkg::S_UPDATE: state_d = mmvc_pkg::S_IDLE;
			default:            state_d = mmvc_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		case (state_q)
			mmvc_pkg::S_CLEAR: cmd.clr_wr = 1'b1;
			mmvc_pkg::S_IDLE: begin
				if (accept) begin
					case (mode)
						mmvc_pkg::MODE_ELEMENT: begin
							// a present element only moves the position on
							cmd.load    = is_missing;
							cmd.advance = !is_missing;
						end
						mmvc_pkg::MODE_READ:    cmd.load       = 1'b1;
						mmvc_pkg::MODE_RESTART: cmd.clr_digits = 1'b1;
						default: ;
					endcase
				end
			end
			mmvc_pkg::S_CALC: cmd.step  = !status.calc_done;
			mmvc_pkg::S_FETCH: cmd.rd_en = 1'b1;
			mmvc_pkg::S_UPDATE: begin
				cmd.reply   = status.read_item;
				cmd.wr_cnt  = !status.read_item;
				cmd.advance = !status.read_item;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/mmvc_dpath.sv =====
// datapath: configuration registers, position digits, index build and count table
// depends on mmvc_pkg and mmvc_ram
`default_nettype none

module mmvc_dpath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [mmvc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mmvc_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire mmvc_pkg::item_t                item,
	input  wire mmvc_pkg::cmd_t                 cmd,
	output mmvc_pkg::status_t                   status,
	output logic                                result_valid,
	output mmvc_pkg::result_t                   result
);

	localparam int unsigned AW   = mmvc_pkg::ADDR_W;
	localparam int unsigned PW   = mmvc_pkg::PROD_W;
	localparam int unsigned DW   = mmvc_pkg::DIG_W;
	localparam int unsigned MW   = PW + DW;
	localparam int unsigned SW   = MW + 1;
	localparam int unsigned CB   = mmvc_pkg::COUNT_BITS;
	localparam int unsigned NDIM = mmvc_pkg::DIM_REGS;

	// configuration registers
	logic [2:0]    in_dims_q;
	logic [DW-1:0] dim_size_q [NDIM];
	logic [2:0]    kept_dims_q;
	logic [7:0]    kept_sel_q;

	// position and index build
	logic [DW-1:0]     digit_q [NDIM];
	logic [DW-1:0]     digit_d [NDIM];
	logic [2:0]        j_q;
	logic [PW-1:0]     p_q;
	logic [AW-1:0]     idx_q;
	logic              ok_q;
	logic              read_q;
	logic [mmvc_pkg::RIDX_W-1:0] ridx_q;
	logic [AW-1:0]     clr_addr_q;

	logic [2:0]    n_use;
	logic [2:0]    k_use;
	logic [1:0]    sel_d;
	logic          sel_in_use;
	logic [DW-1:0] ext;
	logic [DW-1:0] dig;
	logic [MW-1:0] prod_p;
	logic [MW-1:0] prod_i;
	logic [SW-1:0] sum_i;
	logic [PW-1:0] p_next;

	// count table access
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [CB-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [CB-1:0] ram_rdata;
	logic          rd_ok;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_dims_q   <= 3'd1;
			kept_dims_q <= 3'd0;
			kept_sel_q  <= 8'd0;
			for (int i = 0; i < NDIM; i++) dim_size_q[i] <= DW'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				mmvc_pkg::REG_INPUT_DIM_COUNT: in_dims_q     <= cfg_data[2:0];
				mmvc_pkg::REG_DIM0_SIZE:       dim_size_q[0] <= cfg_data;
				mmvc_pkg::REG_DIM1_SIZE:       dim_size_q[1] <= cfg_data;
				mmvc_pkg::REG_DIM2_SIZE:       dim_size_q[2] <= cfg_data;
				mmvc_pkg::REG_DIM3_SIZE:       dim_size_q[3] <= cfg_data;
				mmvc_pkg::REG_KEPT_DIM_COUNT:  kept_dims_q   <= cfg_data[2:0];
				mmvc_pkg::REG_KEPT_DIM_SELECT: kept_sel_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// dimension counts clamped into range
	always_comb begin
		n_use = in_dims_q;
		if (n_use == 3'd0) n_use = 3'd1;
		if (n_use > 3'(mmvc_pkg::DIM_LIM)) n_use = 3'(mmvc_pkg::DIM_LIM);
		k_use = kept_dims_q;
		if (k_use > 3'(mmvc_pkg::DIM_LIM)) k_use = 3'(mmvc_pkg::DIM_LIM);
	end

	// extent and digit of the kept dimension under iteration
	always_comb begin
		sel_d      = kept_sel_q[2 * j_q[1:0] +: 2];
		sel_in_use = ({1'b0, sel_d} < n_use);
		ext        = DW'(1);
		dig        = '0;
		if (sel_in_use) begin
			ext = (dim_size_q[sel_d] == '0) ? DW'(1) : dim_size_q[sel_d];
			dig = digit_q[sel_d];
		end
	end

	// one multiply for the running extent product, one for the digit weight
	always_comb begin
		prod_p = MW'(p_q) * MW'(ext);
		prod_i = MW'(dig) * MW'(p_q);
		sum_i  = SW'(prod_i) + SW'(idx_q);
		p_next = (prod_p >= MW'(mmvc_pkg::TABLE_CELLS)) ?
			PW'(mmvc_pkg::TABLE_CELLS) : prod_p[PW-1:0];
	end

	// index build iteration over kept dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q    <= '0;
			read_q <= 1'b0;
		end else if (cmd.load) begin
			j_q    <= '0;
			read_q <= (item.mode == mmvc_pkg::MODE_READ);
		end else if (cmd.step) begin
			j_q    <= j_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q    <= PW'(1);
			idx_q  <= '0;
			ok_q   <= 1'b1;
			ridx_q <= item.read_index;
		end else if (cmd.step) begin
			p_q   <= p_next;
			idx_q <= sum_i[AW-1:0];
			// digit beyond its extent or index past the table: not counted
			if (dig >= ext || sum_i >= SW'(mmvc_pkg::TABLE_CELLS)) ok_q <= 1'b0;
		end
	end

	// mixed-radix increment of the position with carry
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int d = 0; d < NDIM; d++) begin
			logic [DW-1:0] e;
			e          = (dim_size_q[d] == '0) ? DW'(1) : dim_size_q[d];
			digit_d[d] = digit_q[d];
			if (carry && (3'(d) < n_use)) begin
				if ({1'b0, digit_q[d]} + 17'd1 >= {1'b0, e}) begin
					digit_d[d] = '0;
				end else begin
					digit_d[d] = digit_q[d] + DW'(1);
					carry      = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NDIM; d++) digit_q[d] <= '0;
		end else if (cmd.clr_digits) begin
			for (int d = 0; d < NDIM; d++) digit_q[d] <= '0;
		end else if (cmd.advance) begin
			for (int d = 0; d < NDIM; d++) digit_q[d] <= digit_d[d];
		end
	end

	// clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= status.clr_last ? '0 : clr_addr_q + AW'(1);
		end
	end

	// count table write: clearing or saturating increment
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata + CB'(1);
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else if (cmd.wr_cnt) begin
			ram_we = ok_q && (ram_rdata != {CB{1'b1}});
		end
	end

	assign ram_raddr = read_q ? AW'(ridx_q) : idx_q;

	mmvc_ram #(
		.WIDTH(CB),
		.DEPTH(mmvc_pkg::TABLE_CELLS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.rd_en),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// read reply
	assign rd_ok = (32'(ridx_q) < 32'(p_q)) && (32'(ridx_q) < 32'(mmvc_pkg::TABLE_CELLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.reply;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			result.count_value <= rd_ok ? mmvc_pkg::CNT_OUT_W'(ram_rdata) : '0;
			result.index_valid <= rd_ok;
		end
	end

	// status to the controller
	assign status.calc_done = (j_q == k_use);
	assign status.clr_last  = (clr_addr_q == AW'(mmvc_pkg::TABLE_CELLS - 1));
	assign status.read_item = read_q;

endmodule

`default_nettype wire

// ===== bench/mmvc_checker.sv =====
`timescale 1ns / 100ps
// checker for the marginal missing-value counter: follows the item, result and register
// channels, keeps its own copy of digits, table and registers, and checks every cell read
// depends on mmvc_pkg only
module mmvc_checker
	import mmvc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire item_t                item,
	input  wire logic                 result_valid,
	input  wire result_t              result,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        reads_outstanding
);

	// register copies
	logic [2:0]            dims_reg;
	logic [DIG_W-1:0]      extent_reg [DIM_REGS];
	logic [2:0]            kept_reg;
	logic [7:0]            select_reg;

	// position and count table copies
	logic [DIG_W-1:0]      digit [DIM_REGS];
	logic [COUNT_BITS-1:0] tally [TABLE_CELLS];

	// cell reads still owed by the block, oldest first
	result_t               expected_reads [$];
	result_t               oldest;

	// input dimensions in use, clamped into range
	function automatic int unsigned active_dims();
		int unsigned n;
		n = dims_reg;
		if (n < 1) n = 1;
		if (n > DIM_LIM) n = DIM_LIM;
		return n;
	endfunction

	function automatic int unsigned active_kept();
		return (kept_reg > DIM_LIM) ? DIM_LIM : kept_reg;
	endfunction

	// zero extent counts as one
	function automatic int unsigned dim_extent(input int unsigned d);
		return (extent_reg[d] == 0) ? 1 : extent_reg[d];
	endfunction

	// extent and digit seen by kept dimension j; an unused source dimension is flat
	function automatic void kept_view(input int unsigned j, output longint unsigned e,
			output longint unsigned g);
		int unsigned d;
		d = (select_reg >> (2 * j)) & 8'h03;
		if (d >= active_dims()) begin
			e = 1;
			g = 0;
		end else begin
			e = dim_extent(d);
			g = digit[d];
		end
	endfunction

	// product of the kept extents
	function automatic longint unsigned table_span();
		longint unsigned p;
		longint unsigned e;
		longint unsigned g;
		p = 1;
		for (int unsigned j = 0; j < active_kept(); j++) begin
			kept_view(j, e, g);
			p = p * e;
		end
		return p;
	endfunction

	// count a missing element unless its digits fall outside the table
	function automatic void tally_element();
		longint unsigned idx;
		longint unsigned p;
		longint unsigned e;
		longint unsigned g;
		idx = 0;
		p = 1;
		for (int unsigned j = 0; j < active_kept(); j++) begin
			kept_view(j, e, g);
			if (g >= e) return;
			idx = idx + g * p;
			p = p * e;
		end
		if (idx >= TABLE_CELLS) return;
		if (tally[idx] != '1) tally[idx] = tally[idx] + 1'b1;
	endfunction

	// column-major step with carry; out-of-range digits wrap to zero
	function automatic void advance_digits();
		int unsigned nxt;
		for (int unsigned d = 0; d < active_dims(); d++) begin
			nxt = digit[d] + 1;
			if (nxt >= dim_extent(d)) begin
				digit[d] = '0;
			end else begin
				digit[d] = nxt[DIG_W-1:0];
				return;
			end
		end
	endfunction

	function automatic result_t cell_read(input logic [RIDX_W-1:0] ridx);
		result_t r;
		logic    ok;
		ok = (ridx < table_span()) && (ridx < TABLE_CELLS);
		r.index_valid = ok;
		r.count_value = ok ? tally[ridx][CNT_OUT_W-1:0] : '0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_reg   = 3'd1;
			kept_reg   = 3'd0;
			select_reg = 8'd0;
			foreach (extent_reg[d]) extent_reg[d] = 16'd1;
			foreach (digit[d]) digit[d] = '0;
			foreach (tally[i]) tally[i] = '0;
			expected_reads.delete();
			fail_count = 0;
		end else begin
			// result transfer against the oldest owed read
			if (result_valid) begin
				if (expected_reads.size() == 0) begin
					$display("%0t: result with none owed, got count %0d valid %0b",
						$time, result.count_value, result.index_valid);
					fail_count++;
				end else begin
					oldest = expected_reads.pop_front();
					if (result.count_value !== oldest.count_value) begin
						$display("%0t: count_value mismatch, expected %0d, got %0d",
							$time, oldest.count_value, result.count_value);
						fail_count++;
					end
					if (result.index_valid !== oldest.index_valid) begin
						$display("%0t: index_valid mismatch, expected %0b, got %0b",
							$time, oldest.index_valid, result.index_valid);
						fail_count++;
					end
				end
			end

			// register write transfer
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INPUT_DIM_COUNT: dims_reg = cfg_data[2:0];
					REG_DIM0_SIZE:       extent_reg[0] = cfg_data;
					REG_DIM1_SIZE:       extent_reg[1] = cfg_data;
					REG_DIM2_SIZE:       extent_reg[2] = cfg_data;
					REG_DIM3_SIZE:       extent_reg[3] = cfg_data;
					REG_KEPT_DIM_COUNT:  kept_reg = cfg_data[2:0];
					REG_KEPT_DIM_SELECT: select_reg = cfg_data[7:0];
					default: ;
				endcase
			end

			// item transfer
			if (start && !busy) begin
				case (item.mode)
					MODE_ELEMENT: begin
						if (item.is_missing) tally_element();
						advance_digits();
					end
					MODE_READ: expected_reads.push_back(cell_read(item.read_index));
					MODE_RESTART: begin
						foreach (tally[i]) tally[i] = '0;
						foreach (digit[d]) digit[d] = '0;
					end
					default: ;
				endcase
			end
		end
		reads_outstanding = expected_reads.size();
	end

endmodule

// ===== bench/tb_marginal_missing_value_counter_top.sv =====
`timescale 1ns / 100ps
// bench top for the marginal missing-value counter: clock, reset, item and register
// stimulus, watchdog and verdict; prediction and checking live in mmvc_checker
// depends on mmvc_pkg, mmvc_checker and the counter rtl
module tb_marginal_missing_value_counter_top;
	import mmvc_pkg::*;

	localparam logic [1:0] MODE_UNUSED    = 2'd3;
	localparam int         ITEM_TARGET    = 1800;
	localparam int         QUIET_LIMIT    = 50000;
	localparam int         SETTLE_CYCLES  = 12;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	item_t                item         = '0;
	logic                 cfg_valid    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_INPUT_DIM_COUNT;
	logic [CFG_DAT_W-1:0] cfg_data     = '0;
	logic                 busy;
	logic                 result_valid;
	result_t              result;
	logic                 cfg_ready;

	int fail_count;
	int reads_outstanding;
	int quiet_cycles = 0;
	int items_sent   = 0;
	bit steady       = 1'b0;

	always #6 clk = ~clk;

	marginal_missing_value_counter_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	mmvc_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.item              (item),
		.result_valid      (result_valid),
		.result            (result),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.fail_count        (fail_count),
		.reads_outstanding (reads_outstanding)
	);

	// one item transfer, with random idle cycles carrying noise on the bus unless steady is set
	task automatic send_item(input logic [1:0] op, input logic missing,
			input logic [RIDX_W-1:0] ridx);
		while (!steady && $urandom_range(0, 99) < 32) begin
			start <= 1'b0;
			item  <= item_t'({2'($urandom), 1'($urandom), 12'($urandom)});
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= item_t'({op, missing, ridx});
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
		if (op != MODE_UNUSED) items_sent++;
	endtask

	// hold items off until every owed read has come back
	task automatic drain_reads();
		start <= 1'b0;
		do @(negedge clk); while (reads_outstanding != 0);
	endtask

	// full quiet point: reads back, trailing work done, clearing pass over
	task automatic settle();
		drain_reads();
		repeat (SETTLE_CYCLES) @(negedge clk);
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// write the whole register set
	task automatic write_regs(input logic [2:0] dims, input logic [15:0] e0,
			input logic [15:0] e1, input logic [15:0] e2, input logic [15:0] e3,
			input logic [2:0] kept, input logic [7:0] sel);
		reg_write(REG_INPUT_DIM_COUNT, {13'd0, dims});
		reg_write(REG_DIM0_SIZE, e0);
		reg_write(REG_DIM1_SIZE, e1);
		reg_write(REG_DIM2_SIZE, e2);
		reg_write(REG_DIM3_SIZE, e3);
		reg_write(REG_KEPT_DIM_COUNT, {13'd0, kept});
		reg_write(REG_KEPT_DIM_SELECT, {8'd0, sel});
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// mostly small extents, now and then zero or very large
	function automatic logic [15:0] pick_extent();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'd0;
		if (r == 1) return 16'hFFFF;
		if (r == 2) return 16'($urandom);
		return 16'($urandom_range(1, 6));
	endfunction

	function automatic logic [RIDX_W-1:0] pick_read_index();
		if ($urandom_range(0, 3) == 0) return 12'($urandom);
		return 12'($urandom_range(0, 40));
	endfunction

	task automatic random_setup();
		logic [2:0] dims;
		logic [2:0] kept;
		dims = ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
		kept = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
		write_regs(dims, pick_extent(), pick_extent(), pick_extent(), pick_extent(), kept,
			8'($urandom));
	endtask

	// idle watchdog: counts cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("marginal_missing_value_counter_top verification failed");
		$finish;
	end

	initial begin
		logic [11:0] pattern;
		int          phase_len;
		int          miss_pct;
		int          pick;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		settle();

		// one full 3x2x2 array pass, table keeps dims 2 and 0, dim 3 extent zero
		write_regs(3'd3, 16'd3, 16'd2, 16'd2, 16'd0, 3'd2, 8'h02);
		pattern = 12'b1011_0110_1101;
		for (int i = 0; i < 12; i++) send_item(MODE_ELEMENT, pattern[i], 12'($urandom));
		send_item(MODE_UNUSED, 1'b1, 12'hFFF);
		send_item(MODE_READ, 1'b0, 12'd0);
		send_item(MODE_READ, 1'b1, 12'd2);
		send_item(MODE_READ, 1'b0, 12'd5);
		send_item(MODE_READ, 1'b0, 12'd6);
		send_item(MODE_READ, 1'b1, 12'hFFF);
		send_item(MODE_RESTART, 1'b1, 12'hFFF);
		send_item(MODE_READ, 1'b0, 12'd0);
		settle();

		// over-range counts, all kept dims on dim 3, huge extents
		write_regs(3'd7, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF, 3'd7, 8'hFF);
		for (int i = 0; i < 3; i++) send_item(MODE_ELEMENT, 1'b1, 12'd0);
		send_item(MODE_READ, 1'b0, 12'd0);
		send_item(MODE_READ, 1'b0, 12'hFFF);
		settle();

		// zero dim count, digit left beyond its new extent, then wrap
		write_regs(3'd0, 16'd2, 16'd1, 16'd1, 16'd1, 3'd1, 8'h00);
		send_item(MODE_ELEMENT, 1'b1, 12'd0);
		send_item(MODE_ELEMENT, 1'b1, 12'd0);
		send_item(MODE_READ, 1'b0, 12'd0);
		send_item(MODE_READ, 1'b0, 12'd2);
		settle();

		// random phases, each under a fresh register set
		for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
			steady = (phase >= 8 && phase < 14);
			random_setup();
			miss_pct  = $urandom_range(10, 90);
			phase_len = $urandom_range(40, 80);
			if ($urandom_range(0, 2) == 0) send_item(MODE_RESTART, 1'($urandom), 12'($urandom));
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				if (pick < 62)
					send_item(MODE_ELEMENT, $urandom_range(0, 99) < miss_pct, 12'($urandom));
				else if (pick < 94)
					send_item(MODE_READ, 1'($urandom), pick_read_index());
				else if (pick < 96)
					send_item(MODE_RESTART, 1'($urandom), 12'($urandom));
				else if (pick < 98)
					send_item(MODE_UNUSED, 1'($urandom), 12'($urandom));
				else
					drain_reads();
			end
			settle();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && reads_outstanding == 0) begin
			$display("marginal_missing_value_counter_top verification clean");
		end else begin
			$display("marginal_missing_value_counter_top verification failed");
		end
		$finish;
	end

endmodule
